// ----- rtl/core/c3dc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3dc_pkg: shared types and constants of the 3x3 convolution block
// widths of the fixed fields, register indexes, controller command and status
// ----------------------------------------------------------------------------
package c3dc_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int PIX_W      = 8;
	localparam int COORD_W    = 10;
	localparam int COEF_W     = 8;
	localparam int ROW_TAPS   = 3;
	localparam int COEFF_ROW_W = COEF_W * ROW_TAPS;
	localparam int TAPS       = 9;
	localparam int DIV_W      = 15;
	localparam int SIZE_W     = 11;
	localparam int ACC_W      = 16;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int DIV_STEPS  = ACC_W - 1;
	localparam int STEP_W     = 4;
	localparam int MIN_SIZE   = 3;
	localparam int PIX_MAX    = 255;

	localparam logic [COEFF_ROW_W-1:0] COEFF_TOP_RST    = 24'd0;
	localparam logic [COEFF_ROW_W-1:0] COEFF_MIDDLE_RST = 24'd256;
	localparam logic [COEFF_ROW_W-1:0] COEFF_BOTTOM_RST = 24'd0;
	localparam logic [DIV_W-1:0]       DIVISOR_RST      = 15'd1;
	localparam logic [SIZE_W-1:0]      SIZE_RST         = 11'd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEFF_TOP    = 3'd0,
		REG_COEFF_MIDDLE = 3'd1,
		REG_COEFF_BOTTOM = 3'd2,
		REG_DIVISOR      = 3'd3,
		REG_IMAGE_WIDTH  = 3'd4,
		REG_IMAGE_HEIGHT = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [TAPS*COEF_W-1:0] coeff;    // top row in the low bytes, left tap lowest
		logic [DIV_W-1:0]       divisor;
		logic [SIZE_W-1:0]      image_width;
		logic [SIZE_W-1:0]      image_height;
	} cfg_t;

	typedef struct packed {
		logic              accept;
		logic              shift;
		logic              mac;
		logic              prep;
		logic              div;
		logic              load_out;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic produce;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/c3dc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3dc_ctrl: controller of the 3x3 convolution block
// sequences accept, window shift, multiply-accumulate, divide and output load
// ----------------------------------------------------------------------------
module c3dc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  c3dc_pkg::sts_t     sts,
	output c3dc_pkg::cmd_t     cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SHIFT = 6'b000010,
		S_MAC   = 6'b000100,
		S_PREP  = 6'b001000,
		S_DIV   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [c3dc_pkg::STEP_W-1:0] step_q;
	logic step_last;

	always_comb begin
		step_last = 1'b0;
		if (state_q == S_MAC) begin
			step_last = (step_q == c3dc_pkg::STEP_W'(c3dc_pkg::TAPS - 1));
		end else if (state_q == S_DIV) begin
			step_last = (step_q == c3dc_pkg::STEP_W'(c3dc_pkg::DIV_STEPS - 1));
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.step = step_q;
		state_d  = state_q;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				state_d   = sts.produce ? S_MAC : S_IDLE;
			end
			S_MAC: begin
				cmd.mac = 1'b1;
				if (step_last) state_d = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (step_last) state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if ((cmd.mac || cmd.div) && !step_last) begin
				step_q <= step_q + c3dc_pkg::STEP_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	// an accepted transaction always moves on to the window shift
	a_accept_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid) |=> (state_q == S_SHIFT))
		else $error("accepted pixel did not reach the shift state");

	// the tap counter stays in range in the multiply-accumulate state
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC) |-> (step_q < c3dc_pkg::STEP_W'(c3dc_pkg::TAPS)))
		else $error("tap counter out of range");

	// output register loaded only when it is free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded over an untaken result");

endmodule
`default_nettype wire

// ----- rtl/core/c3dc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3dc_dp: datapath of the 3x3 convolution block
// line stores, window, counters, shared multiply-accumulate, serial divider
// ----------------------------------------------------------------------------
module c3dc_dp #(
	parameter int MAX_WIDTH  = c3dc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = c3dc_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  c3dc_pkg::cfg_t                       cfg,
	input  c3dc_pkg::cmd_t                       cmd,
	output c3dc_pkg::sts_t                       sts,
	input  wire logic [c3dc_pkg::PIX_W-1:0]      pixel_in,
	input  wire logic                            out_stall,
	output logic                                 out_valid,
	output logic [c3dc_pkg::PIX_W-1:0]           pixel_out,
	output logic [c3dc_pkg::COORD_W-1:0]         out_row,
	output logic [c3dc_pkg::COORD_W-1:0]         out_col,
	output logic                                 frame_done
);

	localparam int PW   = c3dc_pkg::PIX_W;
	localparam int CRW  = c3dc_pkg::COORD_W;
	localparam int AW   = c3dc_pkg::ACC_W;
	localparam int DW   = c3dc_pkg::DIV_W;
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int CMPW = (CW + 1 > c3dc_pkg::SIZE_W) ? CW + 1 : c3dc_pkg::SIZE_W;
	localparam int CMPH = (RW + 1 > c3dc_pkg::SIZE_W) ? RW + 1 : c3dc_pkg::SIZE_W;

	// line stores
	logic [PW-1:0] store_a [MAX_WIDTH];
	logic [PW-1:0] store_b [MAX_WIDTH];
	logic [PW-1:0] top_rd_q, mid_rd_q, px_q;

	logic [PW-1:0] window_q [c3dc_pkg::TAPS];
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// effective frame size
	logic [CMPW-1:0] w_ext, ew_full;
	logic [CMPH-1:0] h_ext, eh_full;
	logic [CW:0]     ew, ew_m1, col_ext;
	logic [RW:0]     eh, eh_m1, row_ext;

	always_comb begin
		w_ext = CMPW'(cfg.image_width);
		if (w_ext < CMPW'(c3dc_pkg::MIN_SIZE)) ew_full = CMPW'(c3dc_pkg::MIN_SIZE);
		else if (w_ext > CMPW'(MAX_WIDTH)) ew_full = CMPW'(MAX_WIDTH);
		else ew_full = w_ext;
		h_ext = CMPH'(cfg.image_height);
		if (h_ext < CMPH'(c3dc_pkg::MIN_SIZE)) eh_full = CMPH'(c3dc_pkg::MIN_SIZE);
		else if (h_ext > CMPH'(MAX_HEIGHT)) eh_full = CMPH'(MAX_HEIGHT);
		else eh_full = h_ext;
	end

	assign ew      = ew_full[CW:0];
	assign eh      = eh_full[RW:0];
	assign ew_m1   = ew - (CW+1)'(1);
	assign eh_m1   = eh - (RW+1)'(1);
	assign col_ext = {1'b0, col_q};
	assign row_ext = {1'b0, row_q};

	logic last_col, last_row, is_last;
	assign last_col = (col_ext >= ew_m1);
	assign last_row = (row_ext >= eh_m1);
	assign is_last  = (row_ext == eh_m1) && (col_ext == ew_m1);

	assign sts.produce = (row_q >= RW'(2)) && (col_q >= CW'(2)) &&
		(row_ext < eh) && (col_ext < ew);

	// centre coordinates, fitted to the output field width
	logic [RW-1:0]     row_m1;
	logic [CW-1:0]     col_m1;
	logic [RW+CRW-1:0] row_wide;
	logic [CW+CRW-1:0] col_wide;
	assign row_m1   = row_q - RW'(1);
	assign col_m1   = col_q - CW'(1);
	assign row_wide = {{CRW{1'b0}}, row_m1};
	assign col_wide = {{CRW{1'b0}}, col_m1};

	always_ff @(posedge clk) begin
		top_rd_q <= store_b[col_q];
		mid_rd_q <= store_a[col_q];
		if (cmd.shift) begin
			store_b[col_q] <= mid_rd_q;
			store_a[col_q] <= px_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int i = 0; i < c3dc_pkg::TAPS; i++) window_q[i] <= '0;
		end else if (cmd.shift) begin
			for (int i = 0; i < c3dc_pkg::ROW_TAPS; i++) begin
				window_q[i*3]     <= window_q[i*3 + 1];
				window_q[i*3 + 1] <= window_q[i*3 + 2];
			end
			window_q[2] <= top_rd_q;
			window_q[5] <= mid_rd_q;
			window_q[8] <= px_q;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// shared multiply-accumulate, one tap per cycle
	logic [c3dc_pkg::STEP_W-1:0]        tap;
	logic signed [PW:0]                 w_s;
	logic signed [c3dc_pkg::COEF_W-1:0] c_s;
	logic signed [PW+c3dc_pkg::COEF_W:0] prod;
	assign tap  = (cmd.step < c3dc_pkg::STEP_W'(c3dc_pkg::TAPS)) ? cmd.step : '0;
	assign w_s  = $signed({1'b0, window_q[tap]});
	assign c_s  = $signed(cfg.coeff[tap*c3dc_pkg::COEF_W +: c3dc_pkg::COEF_W]);
	assign prod = w_s * c_s;

	// restoring divider on the magnitude of a non-negative sum
	logic [AW-1:0]   acc_q;
	logic [DW-1:0]   rem_q, d_eff;
	logic [AW-2:0]   quo_q;
	logic            neg_q;
	logic [DW:0]     trial, trial_sub;
	assign d_eff     = (cfg.divisor == '0) ? DW'(1) : cfg.divisor;
	assign trial     = {rem_q, quo_q[AW-2]};
	assign trial_sub = trial - {1'b0, d_eff};

	logic [PW-1:0]  pix_q;
	logic [CRW-1:0] row_hold_q, col_hold_q, row_out_q, col_out_q;
	logic           done_hold_q, done_out_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) px_q <= pixel_in;
		if (cmd.shift) begin
			acc_q       <= '0;
			row_hold_q  <= row_wide[CRW-1:0];
			col_hold_q  <= col_wide[CRW-1:0];
			done_hold_q <= is_last;
		end
		if (cmd.mac) acc_q <= acc_q + prod[AW-1:0];
		if (cmd.prep) begin
			neg_q <= acc_q[AW-1];
			quo_q <= acc_q[AW-2:0];
			rem_q <= '0;
		end
		if (cmd.div) begin
			if (trial >= {1'b0, d_eff}) begin
				rem_q <= trial_sub[DW-1:0];
				quo_q <= {quo_q[AW-3:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[AW-3:0], 1'b0};
			end
		end
		if (cmd.load_out) begin
			if (neg_q) pix_q <= '0;
			else if (|quo_q[AW-2:PW]) pix_q <= PW'(c3dc_pkg::PIX_MAX);
			else pix_q <= quo_q[PW-1:0];
			row_out_q  <= row_hold_q;
			col_out_q  <= col_hold_q;
			done_out_q <= done_hold_q;
		end
	end

	logic out_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign pixel_out    = pix_q;
	assign out_row      = row_out_q;
	assign out_col      = col_out_q;
	assign frame_done   = done_out_q;

endmodule
`default_nettype wire

// ----- rtl/core/conv3x3_divide_clamp_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_divide_clamp_top: 3x3 convolution with divide and clamp
// configuration registers, controller and datapath of the filter
// ----------------------------------------------------------------------------
// One colour plane streams in as 8-bit pixels in raster order, one pixel per
// input transaction. Every interior pixel yields one result: the nine window
// pixels times the signed byte coefficients, summed and wrapped to 16 bits,
// divided by the divisor toward zero and clamped to 0..255, tagged with its
// row, column and a frame_done flag on the last interior pixel. Border pixels
// give no result. A pixel with a result passes through accept, window shift,
// the shared multiply-accumulate over the nine taps, divider load, fifteen
// steps of the bit-serial divider and output load; a border pixel only
// through accept and window shift. The output register lets the next pixel
// in while a result waits to be taken. The line stores need no clearing pass
// after reset. Write the configuration only while the block is idle.
module conv3x3_divide_clamp_top #(
	parameter int MAX_WIDTH  = c3dc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = c3dc_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration write port
	input  wire logic                               cfg_we,
	input  wire logic [c3dc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [c3dc_pkg::CFG_DATA_W-1:0]    cfg_data,
	// pixel input channel
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [c3dc_pkg::PIX_W-1:0]         pixel_in,
	// result channel
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [c3dc_pkg::PIX_W-1:0]              pixel_out,
	output logic [c3dc_pkg::COORD_W-1:0]            out_row,
	output logic [c3dc_pkg::COORD_W-1:0]            out_col,
	output logic                                    frame_done
);

	// configuration registers
	logic [c3dc_pkg::COEFF_ROW_W-1:0] coeff_top_q, coeff_middle_q, coeff_bottom_q;
	logic [c3dc_pkg::DIV_W-1:0]       divisor_q;
	logic [c3dc_pkg::SIZE_W-1:0]      width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_top_q    <= c3dc_pkg::COEFF_TOP_RST;
			coeff_middle_q <= c3dc_pkg::COEFF_MIDDLE_RST;
			coeff_bottom_q <= c3dc_pkg::COEFF_BOTTOM_RST;
			divisor_q      <= c3dc_pkg::DIVISOR_RST;
			width_q        <= c3dc_pkg::SIZE_RST;
			height_q       <= c3dc_pkg::SIZE_RST;
		end else if (cfg_we) begin
			// indexes past the register list are ignored
			unique case (cfg_index)
				c3dc_pkg::REG_COEFF_TOP:    coeff_top_q    <= cfg_data;
				c3dc_pkg::REG_COEFF_MIDDLE: coeff_middle_q <= cfg_data;
				c3dc_pkg::REG_COEFF_BOTTOM: coeff_bottom_q <= cfg_data;
				c3dc_pkg::REG_DIVISOR:      divisor_q <= cfg_data[c3dc_pkg::DIV_W-1:0];
				c3dc_pkg::REG_IMAGE_WIDTH:  width_q   <= cfg_data[c3dc_pkg::SIZE_W-1:0];
				c3dc_pkg::REG_IMAGE_HEIGHT: height_q  <= cfg_data[c3dc_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	c3dc_pkg::cfg_t cfg;
	assign cfg.coeff        = {coeff_bottom_q, coeff_middle_q, coeff_top_q};
	assign cfg.divisor      = divisor_q;
	assign cfg.image_width  = width_q;
	assign cfg.image_height = height_q;

	// controller and datapath talk only through command and status
	c3dc_pkg::cmd_t cmd;
	c3dc_pkg::sts_t sts;

	c3dc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	c3dc_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.sts        (sts),
		.pixel_in   (pixel_in),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.pixel_out  (pixel_out),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_done (frame_done)
	);

endmodule
`default_nettype wire

// ----- tb/conv3x3_divide_clamp_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_divide_clamp_top_tb: self-checking bench of the 3x3 filter
// streams whole pixel planes through the block under several register
// settings, predicts every interior result and checks it field by field
// ----------------------------------------------------------------------------
module conv3x3_divide_clamp_top_tb;

	localparam int MAX_W         = c3dc_pkg::MAX_WIDTH_DEF;
	localparam int MAX_H         = c3dc_pkg::MAX_HEIGHT_DEF;
	localparam int RANDOM_ITEMS  = 220;
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES   = 400;       // long receiver hold-off
	localparam int LIMIT_CYCLES  = 200000;
	localparam int MAX_REPORTS   = 200;

	// one filtered pixel as it leaves the block
	typedef struct packed {
		logic [c3dc_pkg::PIX_W-1:0]   value;
		logic [c3dc_pkg::COORD_W-1:0] row;
		logic [c3dc_pkg::COORD_W-1:0] col;
		logic                         done;
	} filtered_px_t;

	// dut ports, the inputs known from time zero
	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_we    = 1'b0;
	c3dc_pkg::reg_index_t            cfg_index = c3dc_pkg::REG_COEFF_TOP;
	logic [c3dc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic                            in_valid  = 1'b0;
	logic                            in_stall;
	logic [c3dc_pkg::PIX_W-1:0]      pixel_in  = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [c3dc_pkg::PIX_W-1:0]      pixel_out;
	logic [c3dc_pkg::COORD_W-1:0]    out_row;
	logic [c3dc_pkg::COORD_W-1:0]    out_col;
	logic                            frame_done;

	// stimulus and expected results
	logic [c3dc_pkg::PIX_W-1:0] pixel_q[$];
	filtered_px_t               filtered_q[$];
	filtered_px_t               want;

	// shadow of the block: registers, line stores, window, raster counters
	logic [c3dc_pkg::COEFF_ROW_W-1:0] coeff_rows [3];
	logic [c3dc_pkg::DIV_W-1:0]       div_reg;
	logic [c3dc_pkg::SIZE_W-1:0]      width_reg;
	logic [c3dc_pkg::SIZE_W-1:0]      height_reg;
	logic [c3dc_pkg::PIX_W-1:0]       line_a [MAX_W];
	logic [c3dc_pkg::PIX_W-1:0]       line_b [MAX_W];
	logic [c3dc_pkg::PIX_W-1:0]       win [c3dc_pkg::TAPS];
	int                               col_cnt;
	int                               row_cnt;

	int pixels_sent;
	int results_checked;
	int error_count;
	int reports;
	int frames_sent;
	int cycle_count;
	int burst_left;
	int gap_left;
	int hold_requests;
	int hold_served;
	int hold_left;
	int seg_left;
	int stall_mode;

	conv3x3_divide_clamp_top #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out),
		.out_row   (out_row),
		.out_col   (out_col),
		.frame_done(frame_done)
	);

	always #5 clk = ~clk;

	// size registers act clamped to 3..max
	function automatic int eff_size(input logic [c3dc_pkg::SIZE_W-1:0] v, input int hi);
		if (int'(v) < c3dc_pkg::MIN_SIZE)
			return c3dc_pkg::MIN_SIZE;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	// advance the shadow by one pixel; queue the filtered pixel when the
	// window centred one row up and one column left is complete
	function automatic void filter_pixel(input logic [c3dc_pkg::PIX_W-1:0] px);
		int ew, eh, c, r, acc, q, d;
		logic [c3dc_pkg::PIX_W-1:0] top, mid;
		logic signed [c3dc_pkg::COEF_W-1:0] k;
		logic signed [c3dc_pkg::ACC_W-1:0] wrapped;
		filtered_px_t res;
		ew  = eff_size(width_reg, MAX_W);
		eh  = eff_size(height_reg, MAX_H);
		c   = col_cnt;
		r   = row_cnt;
		top = '0;
		mid = '0;
		if (c < MAX_W) begin
			top = line_b[c];
			mid = line_a[c];
			line_b[c] = mid;
			line_a[c] = px;
		end
		for (int i = 0; i < 3; i++) begin
			win[i*3]   = win[i*3+1];
			win[i*3+1] = win[i*3+2];
		end
		win[2] = top;
		win[5] = mid;
		win[8] = px;
		if (r >= 2 && c >= 2 && r < eh && c < ew) begin
			acc = 0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					k = coeff_rows[i][c3dc_pkg::COEF_W*j +: c3dc_pkg::COEF_W];
					acc += int'(win[i*3+j]) * int'(k);
				end
			// the sum lives in a 16-bit signed accumulator
			wrapped = acc[c3dc_pkg::ACC_W-1:0];
			d = (div_reg == 0) ? 1 : int'(div_reg);
			q = int'(wrapped) / d;
			if (q < 0)
				q = 0;
			else if (q > c3dc_pkg::PIX_MAX)
				q = c3dc_pkg::PIX_MAX;
			res.value = q[c3dc_pkg::PIX_W-1:0];
			res.row   = c3dc_pkg::COORD_W'(r - 1);
			res.col   = c3dc_pkg::COORD_W'(c - 1);
			res.done  = (r == eh - 1 && c == ew - 1);
			filtered_q.push_back(res);
		end
		if (c >= ew - 1) begin
			col_cnt = 0;
			row_cnt = (r >= eh - 1) ? 0 : r + 1;
		end else begin
			col_cnt = c + 1;
		end
	endfunction

	// pixels still needed to bring the raster counters back to the frame start
	function automatic int pixels_to_frame_end();
		int ew, eh, c, r, n;
		ew = eff_size(width_reg, MAX_W);
		eh = eff_size(height_reg, MAX_H);
		c  = col_cnt;
		r  = row_cnt;
		n  = 0;
		while (c != 0 || r != 0) begin
			if (c >= ew - 1) begin
				c = 0;
				r = (r >= eh - 1) ? 0 : r + 1;
			end else begin
				c++;
			end
			n++;
		end
		return n;
	endfunction

	function automatic logic [c3dc_pkg::PIX_W-1:0] next_pixel(input int style);
		logic [c3dc_pkg::PIX_W-1:0] p;
		case (style)
			1: p = ($urandom_range(0, 1) != 0) ? c3dc_pkg::PIX_W'(c3dc_pkg::PIX_MAX) : '0;
			2: p = ($urandom_range(0, 1) != 0) ? c3dc_pkg::PIX_W'($urandom_range(0, 15))
				: c3dc_pkg::PIX_W'($urandom_range(240, 255));
			default: p = c3dc_pkg::PIX_W'($urandom_range(0, 255));
		endcase
		return p;
	endfunction

	// caller sits just after a rising edge; the write lands on the next one
	task automatic write_reg(input c3dc_pkg::reg_index_t idx,
		input logic [c3dc_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			c3dc_pkg::REG_COEFF_TOP:    coeff_rows[0] = val;
			c3dc_pkg::REG_COEFF_MIDDLE: coeff_rows[1] = val;
			c3dc_pkg::REG_COEFF_BOTTOM: coeff_rows[2] = val;
			c3dc_pkg::REG_DIVISOR:      div_reg       = val[c3dc_pkg::DIV_W-1:0];
			c3dc_pkg::REG_IMAGE_WIDTH:  width_reg     = val[c3dc_pkg::SIZE_W-1:0];
			c3dc_pkg::REG_IMAGE_HEIGHT: height_reg    = val[c3dc_pkg::SIZE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic program_filter(input logic [c3dc_pkg::CFG_DATA_W-1:0] top, mid, bot,
		dv, w, h);
		write_reg(c3dc_pkg::REG_COEFF_TOP, top);
		write_reg(c3dc_pkg::REG_COEFF_MIDDLE, mid);
		write_reg(c3dc_pkg::REG_COEFF_BOTTOM, bot);
		write_reg(c3dc_pkg::REG_DIVISOR, dv);
		write_reg(c3dc_pkg::REG_IMAGE_WIDTH, w);
		write_reg(c3dc_pkg::REG_IMAGE_HEIGHT, h);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random kernel, divisor and small frame size
	task automatic random_setup();
		logic [c3dc_pkg::CFG_DATA_W-1:0] rows [3];
		logic [c3dc_pkg::CFG_DATA_W-1:0] dv, w, h;
		logic [c3dc_pkg::COEF_W-1:0] b;
		int style, total;
		style = $urandom_range(0, 3);
		total = 0;
		rows[0] = '0;
		rows[1] = '0;
		rows[2] = '0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				case (style)
					0: b = c3dc_pkg::COEF_W'($urandom_range(0, 255));
					1: begin
						b = c3dc_pkg::COEF_W'($urandom_range(0, 15));
						total += int'(b);
					end
					2: b = (i == 1 && j == 1) ? c3dc_pkg::COEF_W'($urandom_range(9, 40))
						: c3dc_pkg::COEF_W'(-int'($urandom_range(0, 8)));
					default: begin
						case ($urandom_range(0, 4))
							0: b = 8'h7f;
							1: b = 8'h80;
							2: b = 8'h00;
							3: b = 8'h01;
							default: b = 8'hff;
						endcase
					end
				endcase
				rows[i][c3dc_pkg::COEF_W*j +: c3dc_pkg::COEF_W] = b;
			end
		case (style)
			0: begin
				case ($urandom_range(0, 3))
					0: dv = 24'd1;
					1: dv = c3dc_pkg::CFG_DATA_W'($urandom_range(1, 64));
					2: dv = c3dc_pkg::CFG_DATA_W'($urandom_range(1, 32767));
					default: dv = 24'd32767;
				endcase
			end
			1: dv = c3dc_pkg::CFG_DATA_W'(total);    // a kernel of zeros leaves a zero divisor
			2: dv = c3dc_pkg::CFG_DATA_W'($urandom_range(1, 4));
			default: begin
				case ($urandom_range(0, 2))
					0: dv = 24'd0;
					1: dv = 24'd1;
					default: dv = 24'd32767;
				endcase
			end
		endcase
		if ($urandom_range(0, 9) == 0)
			w = c3dc_pkg::CFG_DATA_W'($urandom_range(0, 2));
		else if ($urandom_range(0, 4) == 0)
			w = c3dc_pkg::CFG_DATA_W'($urandom_range(13, 48));
		else
			w = c3dc_pkg::CFG_DATA_W'($urandom_range(3, 12));
		h = ($urandom_range(0, 9) == 0) ? c3dc_pkg::CFG_DATA_W'($urandom_range(0, 2))
			: c3dc_pkg::CFG_DATA_W'($urandom_range(3, 8));
		program_filter(rows[0], rows[1], rows[2], dv, w, h);
	endtask

	task automatic stream_pixels(input int count, input int style);
		for (int i = 0; i < count; i++)
			pixel_q.push_back(next_pixel(style));
	endtask

	// all pixels taken, all results back, then let a trailing border pixel finish
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pixel_q.size() != 0 || in_valid || filtered_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// pixel sender: bursts of random length separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			pixel_in   <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			// the accepted pixel moves the shadow on
			if (in_valid && !in_stall) begin
				filter_pixel(pixel_in);
				pixels_sent++;
			end
			// a stalled transaction keeps its payload
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pixel_q.size() != 0) begin
					in_valid <= 1'b1;
					pixel_in <= pixel_q.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver: stall pattern changes per segment; a requested hold-off
	// starts once a result is waiting so that the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall   <= 1'b0;
			hold_served <= 0;
			hold_left   <= 0;
			seg_left    <= 0;
			stall_mode  <= 0;
		end else if (hold_served != hold_requests && out_valid) begin
			hold_served <= hold_requests;
			hold_left   <= HOLD_CYCLES;
			out_stall   <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= (hold_left != 1);
		end else begin
			if (seg_left == 0) begin
				seg_left   <= $urandom_range(4, 60);
				stall_mode <= $urandom_range(0, 3);
			end else begin
				seg_left <= seg_left - 1;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 1) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// result checker: each transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (filtered_q.size() == 0) begin
				error_count++;
				if (reports++ < MAX_REPORTS)
					$display("%0t: unexpected result pixel_out=%0d row=%0d col=%0d frame_done=%0b",
						$time, pixel_out, out_row, out_col, frame_done);
			end else begin
				want = filtered_q.pop_front();
				results_checked++;
				if (pixel_out !== want.value) begin
					error_count++;
					if (reports++ < MAX_REPORTS)
						$display("%0t: pixel_out at (%0d,%0d) expected %0d actual %0d",
							$time, want.row, want.col, want.value, pixel_out);
				end
				if (out_row !== want.row) begin
					error_count++;
					if (reports++ < MAX_REPORTS)
						$display("%0t: out_row expected %0d actual %0d", $time, want.row, out_row);
				end
				if (out_col !== want.col) begin
					error_count++;
					if (reports++ < MAX_REPORTS)
						$display("%0t: out_col expected %0d actual %0d", $time, want.col, out_col);
				end
				if (frame_done !== want.done) begin
					error_count++;
					if (reports++ < MAX_REPORTS)
						$display("%0t: frame_done at (%0d,%0d) expected %0b actual %0b",
							$time, want.row, want.col, want.done, frame_done);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time, filtered_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int random_items, nframes, fp;
		// shadow state after reset
		coeff_rows[0] = c3dc_pkg::COEFF_TOP_RST;
		coeff_rows[1] = c3dc_pkg::COEFF_MIDDLE_RST;
		coeff_rows[2] = c3dc_pkg::COEFF_BOTTOM_RST;
		div_reg       = c3dc_pkg::DIVISOR_RST;
		width_reg     = c3dc_pkg::SIZE_RST;
		height_reg    = c3dc_pkg::SIZE_RST;
		for (int i = 0; i < MAX_W; i++) begin
			line_a[i] = '0;
			line_b[i] = '0;
		end
		for (int i = 0; i < c3dc_pkg::TAPS; i++)
			win[i] = '0;
		col_cnt         = 0;
		row_cnt         = 0;
		pixels_sent     = 0;
		results_checked = 0;
		error_count     = 0;
		reports         = 0;
		frames_sent     = 0;
		cycle_count     = 0;
		hold_requests   = 0;
		random_items    = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset kernel passes the centre through: one 3x3 frame of 0 and 255
		write_reg(c3dc_pkg::REG_IMAGE_WIDTH, 24'd3);
		write_reg(c3dc_pkg::REG_IMAGE_HEIGHT, 24'd3);
		cfg_we <= 1'b0;
		@(posedge clk);
		for (int i = 0; i < 9; i++)
			pixel_q.push_back((i % 2 == 1 || i == 4) ?
				c3dc_pkg::PIX_W'(c3dc_pkg::PIX_MAX) : '0);
		frames_sent++;
		wait_idle();

		// sum overflows 16 bits into a negative value, zero divisor acts as one,
		// width and height below 3 act as 3
		program_filter(24'h007f7f, 24'h800000, 24'hff0000, 24'd0, 24'd2, 24'd0);
		for (int i = 0; i < 9; i++)
			pixel_q.push_back((i == 5) ? '0 : c3dc_pkg::PIX_W'(c3dc_pkg::PIX_MAX));
		frames_sent++;
		wait_idle();

		// random kernels on small frames, whole frames only
		while (random_items < RANDOM_ITEMS) begin
			random_setup();
			fp      = eff_size(width_reg, MAX_W) * eff_size(height_reg, MAX_H);
			nframes = $urandom_range(1, 2);
			repeat (nframes) begin
				stream_pixels(fp, $urandom_range(0, 2));
				frames_sent++;
			end
			random_items += nframes * fp;
			wait_idle();
		end

		// shrink the frame in mid-flight: the column counter sits past the new
		// last column and wraps at the next pixel; all reads hit written columns
		program_filter(24'h010201, 24'h020402, 24'h010201, 24'd16, 24'd10, 24'd8);
		stream_pixels(3 * 10 + 7, 0);
		wait_idle();
		write_reg(c3dc_pkg::REG_IMAGE_WIDTH, 24'd5);
		write_reg(c3dc_pkg::REG_IMAGE_HEIGHT, 24'd6);
		cfg_we <= 1'b0;
		@(posedge clk);
		stream_pixels(pixels_to_frame_end(), 0);
		frames_sent++;
		wait_idle();

		// long receiver hold-off while pixels keep coming
		program_filter(24'h010101, 24'h010801, 24'h010101, 24'd16, 24'd12, 24'd8);
		hold_requests <= hold_requests + 1;
		stream_pixels(12 * 8, 0);
		frames_sent++;
		wait_idle();

		if (filtered_q.size() != 0) begin
			error_count++;
			$display("%0t: %0d expected results never arrived", $time, filtered_q.size());
		end
		$display("%0d frames from 3x3 up to 48 wide, one resized mid-frame, one under a long hold-off",
			frames_sent);
		$display("%0d pixels sent, %0d filtered pixels checked, %0d mismatches",
			pixels_sent, results_checked, error_count);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
